/* rtl/gdcrc_pkg.sv */
// ----------------------------------------------------------------------------
// gdcrc_pkg
// Shared types and constants of the grid column ray caster.
// ----------------------------------------------------------------------------
package gdcrc_pkg;

    localparam int GRID_WIDTH_DEF   = 32;
    localparam int GRID_HEIGHT_DEF  = 32;
    localparam int MAX_STEPS_DEF    = 64;
    localparam int SCREEN_LINES_DEF = 240;

    localparam int CELL_W  = 3;
    localparam int FRAC_W  = 11;
    localparam int QUO_W   = 31;
    localparam int DEN_W   = 16;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
    localparam logic [30:0] DELTA_ONE = 31'h4000_0000;
    localparam logic [15:0] DIST_MIN = 16'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_START,
        S_STEP,
        S_TEST,
        S_DIST,
        S_DIVH,
        S_SPAN,
        S_DONE
    } state_t;

endpackage

/* rtl/gdcrc_ram.sv */
// ----------------------------------------------------------------------------
// gdcrc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module gdcrc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/grid_dda_column_ray_caster.sv */
// ----------------------------------------------------------------------------
// grid_dda_column_ray_caster
// Editable block grid in RAM with a DDA column ray walker.
// ----------------------------------------------------------------------------
// After reset the block clears the grid RAM one cell per cycle, all
// GRID_WIDTH*GRID_HEIGHT cells (1024 by default), before the first beat is
// taken. A write beat writes its cell as it is taken, then passes through the
// done state. A cast beat runs two reciprocal divisions on a shared bit-serial
// divider, a setup state, then up to MAX_STEPS grid steps, each a step and RAM
// read state followed by a test of the read cell; a hit adds one more division
// for the line height and the distance and span states around it. The result
// sits in an output register, so the next beat is taken while it waits.
module grid_dda_column_ray_caster
    import gdcrc_pkg::*;
#(
    parameter int GRID_WIDTH   = gdcrc_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT  = gdcrc_pkg::GRID_HEIGHT_DEF,
    parameter int MAX_STEPS    = gdcrc_pkg::MAX_STEPS_DEF,
    parameter int SCREEN_LINES = gdcrc_pkg::SCREEN_LINES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [4:0]  cell_x,
    input  logic [4:0]  cell_y,
    input  logic [2:0]  cell_type,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic signed [15:0] ray_x,
    input  logic signed [15:0] ray_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic [2:0]  wall_type,
    output logic        hit_side,
    output logic [15:0] distance,
    output logic [6:0]  span_start,
    output logic [7:0]  span_end,
    output logic [2:0]  texture_column
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int GXW   = $clog2(GRID_WIDTH) > $clog2(GRID_HEIGHT) ?
                           $clog2(GRID_WIDTH) : $clog2(GRID_HEIGHT);
    localparam int MXW   = (GXW > 5 ? GXW : 5) + 2;
    localparam int SW    = $clog2(MAX_STEPS);
    localparam int HALF  = SCREEN_LINES / 2;
    localparam logic [30:0] LH_NUM = 31'(SCREEN_LINES * 256);

    function automatic logic signed [16:0] ray_x_ext(input logic signed [15:0] v);
        ray_x_ext = 17'(v);
    endfunction

    state_t state_reg, state_next;

    logic [AW:0]    clr_reg, clr_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [4:0]     cnt_reg, cnt_next;

    logic [15:0]    den_reg, den_next;
    logic [15:0]    rem_reg, rem_next;
    logic [30:0]    quo_reg, quo_next;

    logic [15:0]    px_reg, py_reg;
    logic signed [15:0] rx_reg, ry_reg;
    logic signed [MXW-1:0] mx_reg, my_reg, mx_next, my_next;
    logic [31:0]    ddx_reg, ddy_reg, sdx_reg, sdy_reg, perp_reg;
    logic           side_reg;
    logic [2:0]     type_reg;
    logic [15:0]    d_reg;
    logic signed [32:0] prod_reg;

    logic           res_hit_reg;
    logic [15:0]    res_dist_reg;
    logic [6:0]     res_y0_reg;
    logic [7:0]     res_y1_reg;
    logic [2:0]     res_tx_reg;

    logic           hit_reg;
    logic [2:0]     wall_type_reg;
    logic           hit_side_reg;
    logic [15:0]    distance_reg;
    logic [6:0]     span_start_reg;
    logic [7:0]     span_end_reg;
    logic [2:0]     texture_column_reg;

    logic           out_valid_reg;
    logic           load_out;

    // RAM port signals
    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [2:0]     ram_wdata, ram_rdata;

    gdcrc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Divider trial subtraction, one quotient bit per cycle.
    logic [16:0] trial;
    logic        qbit;
    logic [30:0] quo_step;
    always_comb
    begin
        trial    = {rem_reg, quo_reg[30]};
        qbit     = (trial >= {1'b0, den_reg});
        quo_step = {quo_reg[29:0], qbit};
    end

    // Next DDA step.
    logic        take_x;
    logic [32:0] sum_x, sum_y;
    logic        oob;
    always_comb
    begin
        take_x  = (sdx_reg < sdy_reg);
        sum_x   = {1'b0, sdx_reg} + {1'b0, ddx_reg};
        sum_y   = {1'b0, sdy_reg} + {1'b0, ddy_reg};
        mx_next = mx_reg;
        my_next = my_reg;
        if (take_x)
        begin
            mx_next = rx_reg[15] ? mx_reg - MXW'(1) : mx_reg + MXW'(1);
        end
        else
        begin
            my_next = ry_reg[15] ? my_reg - MXW'(1) : my_reg + MXW'(1);
        end
        oob = mx_next[MXW-1] || my_next[MXW-1] ||
              (mx_next >= $signed(MXW'(GRID_WIDTH))) ||
              (my_next >= $signed(MXW'(GRID_HEIGHT)));
    end

    // Distance in Q8.8, saturated and floored at the least value above 0.01.
    logic [15:0] d_calc;
    always_comb
    begin
        if (perp_reg[31:24] != 8'd0)
        begin
            d_calc = 16'hFFFF;
        end
        else if (perp_reg[23:8] < DIST_MIN)
        begin
            d_calc = DIST_MIN;
        end
        else
        begin
            d_calc = perp_reg[23:8];
        end
    end

    // Wall span and texture column.
    logic [16:0] lh, half_h;
    logic [17:0] y1_sum;
    logic [21:0] wall_w;
    logic [15:0] opos;
    always_comb
    begin
        lh     = (quo_reg[30:17] != 14'd0) ? 17'h1FFFF : quo_reg[16:0];
        if (lh == 17'd0)
        begin
            lh = 17'd1;
        end
        half_h = lh >> 1;
        y1_sum = 18'(HALF) + {1'b0, half_h};
        opos   = side_reg ? px_reg : py_reg;
        wall_w = {opos[10:0], 11'd0} + prod_reg[21:0];
    end

    logic [11:0] fx, fy;
    logic [15:0] ay;
    always_comb
    begin
        fx = rx_reg[15] ? {1'b0, px_reg[10:0]} : 12'd2048 - {1'b0, px_reg[10:0]};
        fy = ry_reg[15] ? {1'b0, py_reg[10:0]} : 12'd2048 - {1'b0, py_reg[10:0]};
        ay = ry_reg[15] ? 16'(-ray_x_ext(ry_reg)) : 16'(ry_reg);
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            step_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    px_reg      <= pos_x;
                    py_reg      <= pos_y;
                    rx_reg      <= ray_x;
                    ry_reg      <= ray_y;
                    mx_reg      <= MXW'(pos_x[15:11]);
                    my_reg      <= MXW'(pos_y[15:11]);
                    res_hit_reg <= 1'b0;
                    type_reg    <= '0;
                    side_reg    <= 1'b0;
                    res_dist_reg <= '0;
                    res_y0_reg  <= '0;
                    res_y1_reg  <= '0;
                    res_tx_reg  <= '0;
                end
            end
            S_DIVX:
            begin
                if (cnt_reg == 5'd0)
                begin
                    ddx_reg <= (rx_reg == 16'sd0) ? SAT32 : {1'b0, quo_step};
                end
            end
            S_DIVY:
            begin
                if (cnt_reg == 5'd0)
                begin
                    ddy_reg <= (ry_reg == 16'sd0) ? SAT32 : {1'b0, quo_step};
                end
            end
            S_START:
            begin
                sdx_reg <= 32'((44'(fx) * 44'(ddx_reg)) >> FRAC_W);
                sdy_reg <= 32'((44'(fy) * 44'(ddy_reg)) >> FRAC_W);
            end
            S_STEP:
            begin
                mx_reg <= mx_next;
                my_reg <= my_next;
                if (take_x)
                begin
                    perp_reg <= sdx_reg;
                    sdx_reg  <= sum_x[32] ? SAT32 : sum_x[31:0];
                    side_reg <= 1'b0;
                end
                else
                begin
                    perp_reg <= sdy_reg;
                    sdy_reg  <= sum_y[32] ? SAT32 : sum_y[31:0];
                    side_reg <= ~oob;
                end
                if (oob)
                begin
                    res_dist_reg <= 16'hFFFF;
                    res_y0_reg   <= 7'(HALF);
                    res_y1_reg   <= 8'(HALF);
                end
            end
            S_TEST:
            begin
                type_reg <= ram_rdata;
                d_reg    <= d_calc;
                if (ram_rdata == 3'd0 && step_reg == SW'(MAX_STEPS - 1))
                begin
                    res_dist_reg <= 16'hFFFF;
                    res_y0_reg   <= 7'(HALF);
                    res_y1_reg   <= 8'(HALF);
                    side_reg     <= 1'b0;
                end
            end
            S_DIST:
            begin
                prod_reg <= $signed({1'b0, d_reg}) *
                            (side_reg ? ray_x_ext(rx_reg) : ray_x_ext(ry_reg));
            end
            S_SPAN:
            begin
                res_hit_reg  <= 1'b1;
                res_dist_reg <= d_reg;
                res_y0_reg   <= (half_h >= 17'(HALF)) ? 7'd0 : 7'(17'(HALF) - half_h);
                res_y1_reg   <= (y1_sum > 18'(SCREEN_LINES)) ? 8'(SCREEN_LINES)
                                                              : 8'(y1_sum);
                res_tx_reg   <= wall_w[21:19];
            end
            default:
            begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hit_reg            <= res_hit_reg;
            wall_type_reg      <= res_hit_reg ? type_reg : 3'd0;
            hit_side_reg       <= res_hit_reg ? side_reg : 1'b0;
            distance_reg       <= res_dist_reg;
            span_start_reg     <= res_y0_reg;
            span_end_reg       <= res_y1_reg;
            texture_column_reg <= res_tx_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign wall_type      = wall_type_reg;
    assign hit_side       = hit_side_reg;
    assign distance       = distance_reg;
    assign span_start     = span_start_reg;
    assign span_end       = span_end_reg;
    assign texture_column = texture_column_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        ram_we     = 1'b0;
        ram_waddr  = clr_reg[AW-1:0];
        ram_wdata  = '0;
        ram_raddr  = AW'(32'(my_next) * 32'(GRID_WIDTH) + 32'(mx_next));

        if (state_reg == S_DIVX || state_reg == S_DIVY || state_reg == S_DIVH)
        begin
            rem_next = qbit ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            quo_next = quo_step;
            cnt_next = cnt_reg - 5'd1;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                clr_next = clr_reg + (AW + 1)'(1);
                if (clr_reg == (AW + 1)'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_WRITE)
                    begin
                        ram_we    = (32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT);
                        ram_waddr = AW'(32'(cell_y) * 32'(GRID_WIDTH) + 32'(cell_x));
                        ram_wdata = cell_type;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        den_next   = ray_x[15] ? 16'(-ray_x_ext(ray_x)) : ray_x;
                        rem_next   = '0;
                        quo_next   = DELTA_ONE;
                        cnt_next   = 5'(QUO_W - 1);
                        step_next  = '0;
                        state_next = S_DIVX;
                    end
                end
            end
            S_DIVX:
            begin
                if (cnt_reg == 5'd0)
                begin
                    den_next   = ay;
                    rem_next   = '0;
                    quo_next   = DELTA_ONE;
                    cnt_next   = 5'(QUO_W - 1);
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_STEP;
            end
            S_STEP:
            begin
                state_next = oob ? S_DONE : S_TEST;
            end
            S_TEST:
            begin
                if (ram_rdata != 3'd0)
                begin
                    state_next = S_DIST;
                end
                else if (step_reg == SW'(MAX_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next  = step_reg + SW'(1);
                    state_next = S_STEP;
                end
            end
            S_DIST:
            begin
                den_next   = d_reg;
                rem_next   = '0;
                quo_next   = LH_NUM;
                cnt_next   = 5'(QUO_W - 1);
                state_next = S_DIVH;
            end
            S_DIVH:
            begin
                if (cnt_reg == 5'd0)
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
